// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is low
`define AGC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped while reset is low
`define AGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/agc_pkg.sv =====
package agc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int ENV_W      = SAMPLE_W + FRAC_W;
    localparam int TGT_W      = 15;
    localparam int COEF_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_FRAC  = 8;
    // target is shifted so that target / envelope lands in Q8.8
    localparam int TGT_SHIFT  = SAMPLE_W - GAIN_FRAC;
    localparam int MUL_A_W    = (COEF_W + 2 > SAMPLE_W) ? COEF_W + 2 : SAMPLE_W;
    localparam int MUL_B_W    = ENV_W + 1;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_CNT_W  = $clog2(GAIN_W);

    localparam logic [TGT_W-1:0]  TARGET_RST  = TGT_W'(16384);
    localparam logic [GAIN_W-1:0] LIMIT_RST   = GAIN_W'(2560);
    localparam logic [COEF_W-1:0] ATTACK_RST  = COEF_W'(64000);
    localparam logic [COEF_W-1:0] RELEASE_RST = COEF_W'(65400);
    localparam logic [GAIN_W-1:0] GAIN_RST    = GAIN_W'(256);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET  = 2'd0,
        REG_LIMIT   = 2'd1,
        REG_ATTACK  = 2'd2,
        REG_RELEASE = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

// ===== hw/rtl/agc_mul.sv =====
module agc_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [agc_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [agc_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [agc_pkg::MUL_P_W-1:0]   o_prod
);
    import agc_pkg::*;

    logic signed [MUL_P_W-1:0] r_prod;

    // product held until the next enabled pass
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/agc_div.sv =====
module agc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [agc_pkg::TGT_W-1:0]       i_dividend,
    input  logic [agc_pkg::ENV_W-1:0]       i_divisor,
    output logic [agc_pkg::GAIN_W-1:0]      o_quotient,
    output agc_pkg::t_div_stat              o_stat
);
    import agc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_ovf;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ENV_W-1:0]     r_rem;
    logic [ENV_W-1:0]     r_den;
    logic [GAIN_W-1:0]    r_quo;

    logic [ENV_W-1:0]     w_num;
    logic [ENV_W:0]       w_shl;
    logic [ENV_W:0]       w_diff;
    logic                 w_ge;

    // target scaled; dividend's low 16 bits are zero and enter one per step
    assign w_num  = ENV_W'(i_dividend) << TGT_SHIFT;
    assign w_shl  = {r_rem, 1'b0};
    assign w_ge   = w_shl >= {1'b0, r_den};
    assign w_diff = w_shl - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(GAIN_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_num;
            r_den <= i_divisor;
            r_quo <= '0;
            // quotient would need more than 16 bits
            r_ovf <= w_num >= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[ENV_W-1:0] : w_shl[ENV_W-1:0];
            r_quo <= {r_quo[GAIN_W-2:0], w_ge};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;

endmodule

// ===== hw/rtl/automatic_gain_control_core.sv =====
// Automatic gain control, peak envelope follower. Each input beat is one signed
// sample; each gives exactly one output beat with the scaled, saturated sample
// and the Q8.8 gain used for it. The envelope (32 bits, 16 fraction bits) moves
// toward the sample magnitude by the attack factor when the magnitude is above
// it and by the release factor otherwise, and never drops below one code. The
// gain is target / envelope in Q8.8, clipped to the gain limit. Each sample
// goes through the serial divider, one quotient bit per cycle for 16 bits,
// and makes three passes through the one shared registered multiplier. A
// finished result sits in an output register, so the next sample is taken
// while it waits; only the final write stalls if that register is still full.
// Registers are to be written through the write port only while the block is
// idle; the block itself does not enforce this. There is no read-back.
module automatic_gain_control_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [agc_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [agc_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic [agc_pkg::GAIN_W-1:0]           o_applied_gain,
    input  logic                                 i_cfg_we,
    input  logic [agc_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [agc_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import agc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_MUL_ENV  = 8'b0000_0010,
        S_MUL_IN   = 8'b0000_0100,
        S_SUM      = 8'b0000_1000,
        S_DIV_GO   = 8'b0001_0000,
        S_DIV_WAIT = 8'b0010_0000,
        S_MUL_OUT  = 8'b0100_0000,
        S_SAT      = 8'b1000_0000
    } t_state;

    localparam logic [COEF_W:0] COEF_ONE = (COEF_W + 1)'(1) << COEF_W;
    localparam logic signed [MUL_P_W-1:0] OUT_MAX = MUL_P_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [MUL_P_W-1:0] OUT_MIN = -OUT_MAX - MUL_P_W'(1);

    // control
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    // configuration
    logic [TGT_W-1:0]  r_target;
    logic [GAIN_W-1:0] r_limit;
    logic [COEF_W-1:0] r_attack;
    logic [COEF_W-1:0] r_release;

    // follower state
    logic [ENV_W-1:0]  r_env;
    logic [GAIN_W-1:0] r_gain;

    // per-sample working registers
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0]        r_mag;
    logic [COEF_W-1:0]          r_k;
    logic [ENV_W-1:0]           r_acc;

    // output register
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic [GAIN_W-1:0]          r_out_gain;

    logic                       w_in_beat;
    logic                       w_out_free;
    logic [SAMPLE_W-1:0]        w_mag;
    logic [ENV_W-1:0]           w_x;
    logic [ENV_W:0]             w_env_sum;
    logic [ENV_W-1:0]           w_env_new;
    logic [GAIN_W-1:0]          w_gain;
    logic signed [MUL_P_W-1:0]  w_scaled;
    logic signed [SAMPLE_W-1:0] w_sat;

    // shared multiplier
    logic                       w_mul_en;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [MUL_P_W-1:0]  w_prod;

    // serial divider
    logic                       w_div_start;
    logic [GAIN_W-1:0]          w_quo;
    t_div_stat                  w_div_stat;

    assign o_in_ready = r_state == S_IDLE;
    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // magnitude of the incoming sample; most negative value maps to 2^(w-1)
    assign w_mag = i_sample_in[SAMPLE_W-1] ? SAMPLE_W'(~i_sample_in) + SAMPLE_W'(1)
                                           : SAMPLE_W'(i_sample_in);
    assign w_x   = {w_mag, FRAC_W'(0)};

    // floor((k*env + (1-k)*x) / 2^16) = (k*env >> 16) + (1-k)*mag
    assign w_env_sum = {1'b0, r_acc} + (ENV_W + 1)'(w_prod[ENV_W-1:0]);
    // envelope floor of one code keeps the divisor nonzero
    assign w_env_new = (w_env_sum[ENV_W-1:0] == '0) ? ENV_W'(1) : w_env_sum[ENV_W-1:0];

    // divider overflow means the quotient is past any 16-bit limit
    assign w_gain = (w_div_stat.ovf || (w_quo > r_limit)) ? r_limit : w_quo;

    // floor divide by 256, then clip to the sample range
    assign w_scaled = w_prod >>> GAIN_FRAC;
    always_comb begin
        if (w_scaled > OUT_MAX) begin
            w_sat = SAMPLE_W'(OUT_MAX);
        end else if (w_scaled < OUT_MIN) begin
            w_sat = SAMPLE_W'(OUT_MIN);
        end else begin
            w_sat = SAMPLE_W'(w_scaled);
        end
    end

    // operand select for the three multiplier passes
    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            S_MUL_ENV: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_k);
                w_mul_b  = MUL_B_W'(r_env);
            end
            S_MUL_IN: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(COEF_ONE - {1'b0, r_k});
                w_mul_b  = MUL_B_W'(r_mag);
            end
            S_MUL_OUT: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_sample);
                w_mul_b  = MUL_B_W'(r_gain);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    assign w_div_start = r_state == S_DIV_GO;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_in_beat) n_state = S_MUL_ENV;
            S_MUL_ENV:  n_state = S_MUL_IN;
            S_MUL_IN:   n_state = S_SUM;
            S_SUM:      n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (w_div_stat.done) n_state = S_MUL_OUT;
            S_MUL_OUT:  n_state = S_SAT;
            S_SAT:      if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SAT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers, upper data bits dropped for the target
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= TARGET_RST;
            r_limit   <= LIMIT_RST;
            r_attack  <= ATTACK_RST;
            r_release <= RELEASE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_TARGET:  r_target  <= i_cfg_wdata[TGT_W-1:0];
                REG_LIMIT:   r_limit   <= i_cfg_wdata[GAIN_W-1:0];
                REG_ATTACK:  r_attack  <= i_cfg_wdata[COEF_W-1:0];
                REG_RELEASE: r_release <= i_cfg_wdata[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // envelope and gain carry over between samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env  <= '0;
            r_gain <= GAIN_RST;
        end else begin
            if (r_state == S_SUM) begin
                r_env <= w_env_new;
            end
            if (r_state == S_DIV_WAIT && w_div_stat.done) begin
                r_gain <= w_gain;
            end
        end
    end

    // working and output payload
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_sample <= i_sample_in;
            r_mag    <= w_mag;
            // attack when the magnitude climbs above the envelope
            r_k      <= (w_x > r_env) ? r_attack : r_release;
        end
        if (r_state == S_MUL_IN) begin
            r_acc <= w_prod[ENV_W+FRAC_W-1:FRAC_W];
        end
        if (r_state == S_SAT && w_out_free) begin
            r_sample_out <= w_sat;
            r_out_gain   <= r_gain;
        end
    end

    agc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    agc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_target),
        .i_divisor  (r_env),
        .o_quotient (w_quo),
        .o_stat     (w_div_stat)
    );

    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = r_sample_out;
    assign o_applied_gain = r_out_gain;

endmodule

// ===== hw/rtl/agc_checker.sv =====
`include "assert_macros.svh"

module agc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [agc_pkg::SAMPLE_W-1:0]  o_sample_out,
    input logic [agc_pkg::GAIN_W-1:0]           o_applied_gain
);
    import agc_pkg::*;

    // a stalled result beat holds
    `AGC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "output beat dropped while stalled")
    `AGC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_sample_out) && $stable(o_applied_gain), "output payload changed while stalled")

    // block is busy right after taking a sample
    `AGC_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input taken while a sample is in work")

    // a new result only comes out of a busy cycle
    `AGC_ASSERT_SAME(a_out_from_work, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready), "result appeared without a sample in work")

    // zero gain gives silence
    `AGC_ASSERT_SAME(a_zero_gain, i_clk, i_rst_n, o_out_valid && o_applied_gain == '0, o_sample_out == '0, "nonzero output at zero gain")

endmodule

bind automatic_gain_control_core agc_checker u_agc_checker (.*);

// ===== bench/automatic_gain_control_core_tb.sv =====
`timescale 1ns / 100ps

module automatic_gain_control_core_tb;
    import agc_pkg::*;

    // watchdog limit in cycles with no beat on any port, and the drain after the last result
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_ITEMS = 150;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [GAIN_W-1:0]          gain;
    } t_scaled_beat;

    // dut ports; the inputs are known from time zero
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b1;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic [GAIN_W-1:0]          o_applied_gain;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]      i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_wdata = '0;

    automatic_gain_control_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_in    (i_sample_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_out   (o_sample_out),
        .o_applied_gain (o_applied_gain),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // samples waiting to be driven, and scaled beats waiting to come out
    logic signed [SAMPLE_W-1:0] pending_samples[$];
    t_scaled_beat               expected_scaled[$];

    // shadow of the gain loop: register copies plus envelope state
    logic [TGT_W-1:0]  shadow_target;
    logic [GAIN_W-1:0] shadow_limit;
    logic [COEF_W-1:0] shadow_attack;
    logic [COEF_W-1:0] shadow_release;
    logic [ENV_W-1:0]  envelope_track;

    // bookkeeping
    bit          sample_taken = 1'b0;
    bit          steady_flow = 1'b0;
    int unsigned feed_hold = 0;
    int unsigned drain_hold = 0;
    int unsigned quiet_cycles = 0;
    int unsigned fault_count = 0;
    int unsigned samples_in = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned settings_used = 1;
    int unsigned sat_hits = 0;
    int unsigned limit_hits = 0;
    int unsigned floor_hits = 0;

    // envelope follower, gain division, clamp and scaling for one sample
    function automatic t_scaled_beat predict_scaled_sample(input logic signed [SAMPLE_W-1:0] smp);
        longint          smp_s;
        longint unsigned mag;
        longint unsigned peak;
        longint unsigned k;
        longint unsigned env_next;
        longint unsigned tgt;
        longint unsigned gain_q;
        longint          gain_s;
        longint          scaled;
        t_scaled_beat    beat;
        smp_s = smp;
        mag = (smp_s < 0) ? -smp_s : smp_s;
        // magnitude lifted into the envelope's 16 fraction bits
        peak = mag << FRAC_W;
        k = (peak > envelope_track) ? shadow_attack : shadow_release;
        env_next = (k * envelope_track + (64'd65536 - k) * peak) >> FRAC_W;
        // envelope never drops below one code so the divide is safe
        if (env_next == 0) begin
            env_next = 1;
            floor_hits++;
        end
        envelope_track = env_next[ENV_W-1:0];
        tgt = shadow_target;
        gain_q = (tgt << (SAMPLE_W + GAIN_FRAC)) / env_next;
        if (gain_q > shadow_limit) begin
            gain_q = shadow_limit;
            limit_hits++;
        end
        gain_s = gain_q;
        // arithmetic shift gives floor for negative products
        scaled = (smp_s * gain_s) >>> GAIN_FRAC;
        if (scaled > 32767) begin
            scaled = 32767;
            sat_hits++;
        end else if (scaled < -32768) begin
            scaled = -32768;
            sat_hits++;
        end
        beat.sample = scaled[SAMPLE_W-1:0];
        beat.gain = gain_q[GAIN_W-1:0];
        return beat;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // mostly short gaps, some medium, a few long ones
    function automatic int unsigned pick_idle_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50) return 0;
        else if (roll < 85) return $urandom_range(1, 4);
        else if (roll < 97) return $urandom_range(5, 40);
        else return $urandom_range(41, 200);
    endfunction

    // sample side: hold valid and payload until the beat is taken
    always @(negedge i_clk) begin
        if (!i_in_valid || sample_taken) begin
            if (feed_hold != 0) begin
                feed_hold <= feed_hold - 1;
                i_in_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                i_sample_in <= pending_samples.pop_front();
                i_in_valid <= 1'b1;
                feed_hold <= steady_flow ? 0 : pick_idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side: random backpressure stretches
    always @(negedge i_clk) begin
        if (drain_hold != 0) begin
            drain_hold <= drain_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!steady_flow && $urandom_range(3) == 0) begin
                drain_hold <= pick_idle_len();
            end
        end
    end

    // shadow model update, result check and watchdog, all on the sampling edge
    always @(posedge i_clk) begin : check_blk
        t_scaled_beat want;
        bit           moved;
        sample_taken <= i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            shadow_target = TARGET_RST;
            shadow_limit = LIMIT_RST;
            shadow_attack = ATTACK_RST;
            shadow_release = RELEASE_RST;
            envelope_track = '0;
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            // register writes land on the same edge as in the block
            if (i_cfg_we) begin
                moved = 1'b1;
                case (t_cfg_reg'(i_cfg_addr))
                    REG_TARGET:  shadow_target = i_cfg_wdata[TGT_W-1:0];
                    REG_LIMIT:   shadow_limit = i_cfg_wdata[GAIN_W-1:0];
                    REG_ATTACK:  shadow_attack = i_cfg_wdata[COEF_W-1:0];
                    REG_RELEASE: shadow_release = i_cfg_wdata[COEF_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                expected_scaled.push_back(predict_scaled_sample(i_sample_in));
                samples_in++;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (expected_scaled.size() == 0) begin
                    note_fault($sformatf("result beat with nothing expected: sample %0d gain %0d",
                        o_sample_out, o_applied_gain));
                end else begin
                    want = expected_scaled.pop_front();
                    results_checked++;
                    if (o_sample_out !== want.sample) begin
                        note_fault($sformatf("result %0d sample_out expected %0d got %0d",
                            results_checked, want.sample, o_sample_out));
                    end
                    if (o_applied_gain !== want.gain) begin
                        note_fault($sformatf("result %0d applied_gain expected %0d got %0d",
                            results_checked, want.gain, o_applied_gain));
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                    quiet_cycles, expected_scaled.size());
                $display("automatic_gain_control_core test failed");
                $finish;
            end
        end
    end

    // returns on a falling edge once the block has nothing in flight
    task automatic settle_idle();
        do @(posedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || expected_scaled.size() != 0);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        reg_writes++;
    endtask

    // all four registers, target with a random unused top bit
    task automatic program_agc(input logic [TGT_W-1:0] tgt, input logic [GAIN_W-1:0] lim,
                               input logic [COEF_W-1:0] att, input logic [COEF_W-1:0] rel);
        logic spare;
        spare = $urandom_range(1);
        settle_idle();
        write_reg(REG_TARGET, {spare, tgt});
        write_reg(REG_LIMIT, lim);
        write_reg(REG_ATTACK, att);
        write_reg(REG_RELEASE, rel);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [COEF_W-1:0] pick_factor();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: return COEF_W'($urandom);
            default: return COEF_W'($urandom_range(58000, 65535));
        endcase
    endfunction

    // random phase: segments of one signal style so the envelope builds and decays
    task automatic queue_random_phase();
        int unsigned n;
        int unsigned seg_len;
        int unsigned style;
        int          amp;
        int          val;
        n = 0;
        while (n < PHASE_ITEMS) begin
            seg_len = $urandom_range(1, 40);
            style = $urandom_range(6);
            amp = $urandom_range(32767);
            for (int unsigned j = 0; j < seg_len && n < PHASE_ITEMS; j++) begin
                case (style)
                    0, 1: val = int'($urandom);
                    2:    val = int'($urandom_range(511)) - 256;
                    3:    val = int'($urandom_range(8191)) - 4096;
                    4:    val = 0;
                    5: begin
                        case ($urandom_range(3))
                            0: val = 32767;
                            1: val = -32768;
                            2: val = 1;
                            default: val = -1;
                        endcase
                    end
                    default: val = j[0] ? amp : -amp;
                endcase
                pending_samples.push_back(SAMPLE_W'(val));
                n++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: silence, both full-scale ends, one-code steps, bit patterns
        pending_samples = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd1,
                            16'sh5555, 16'shAAAA, 16'sd0};

        // slowest attack, no hold on release: envelope floors at one code on silence,
        // huge gain then saturates on both signs
        program_agc('1, '1, '1, '0);
        pending_samples = '{16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 16'sd0, -16'sd1,
                            16'sh0100};

        // zero gain limit mutes everything
        program_agc(TGT_W'(12345), '0, '0, '1);
        pending_samples = '{16'sd1000, -16'sd1000, -16'sd32768, 16'sd32767};

        // zero target gives zero gain
        program_agc('0, '1, COEF_W'(30000), COEF_W'(30000));
        pending_samples = '{16'sd500, -16'sd500, 16'sd0};

        for (int unsigned r = 0; r < RANDOM_PHASES; r++) begin
            case (r)
                0: program_agc(TARGET_RST, LIMIT_RST, ATTACK_RST, RELEASE_RST);
                5: program_agc('1, '1, '1, '1);
                default: begin
                    program_agc(
                        ($urandom_range(3) == 0) ? TGT_W'($urandom) :
                            TGT_W'($urandom_range(1000, 32767)),
                        ($urandom_range(5) == 0) ? GAIN_W'($urandom) :
                            GAIN_W'($urandom_range(256, 8192)),
                        pick_factor(),
                        pick_factor());
                end
            endcase
            // one phase with no idling on either side
            steady_flow = (r == 2);
            queue_random_phase();
        end

        settle_idle();
        steady_flow = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d samples under %0d register settings (%0d writes), %0d results checked",
            samples_in, settings_used, reg_writes, results_checked);
        $display("%0d saturated outputs, %0d gains at the limit, %0d envelope floor hits, %0d faults",
            sat_hits, limit_hits, floor_hits, fault_count);
        if (expected_scaled.size() != 0) begin
            $display("%0d expected results never arrived", expected_scaled.size());
        end
        if (fault_count == 0 && expected_scaled.size() == 0) begin
            $display("automatic_gain_control_core test passed");
        end else begin
            $display("automatic_gain_control_core test failed");
        end
        $finish;
    end

endmodule
